FILE: design/buzzer_tone_scale_sequencer_unit_macros.svh
// assertion macros used by the top-level design file
`ifndef BUZZER_TONE_SCALE_SEQUENCER_UNIT_MACROS_SVH
`define BUZZER_TONE_SCALE_SEQUENCER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// checked only out of reset
`define BTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// checked at every edge, reset included
`define BTS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define BTS_ASSERT(lbl, prop, msg)
`define BTS_ASSERT_RST(lbl, prop, msg)
`endif
`endif

FILE: design/bts_pkg.sv
package bts_pkg;

  localparam int FREQ_W = 16;
  localparam int DUTY_W = 20;
  localparam int DUR_W  = 32;
  localparam int POS_W  = 8;
  localparam int PRE_W  = 30;

  // duty scaling: full * d / 10000 = ((full * d) >> 4) / 625
  localparam logic [13:0] DUTY_FULL    = 14'd10000;
  localparam logic [4:0]  MAX_RES_BITS = 5'd20;
  localparam int          DUTY_SHIFT   = 40;
  localparam logic [30:0] DUTY_RECIP   = 31'(((64'd1 << DUTY_SHIFT) + 64'd624) / 64'd625);

  typedef enum logic [2:0] {
    CMD_TICK        = 3'd0,
    CMD_DUTY_TONE   = 3'd1,
    CMD_SQUARE_TONE = 3'd2,
    CMD_LOAD_NOTE   = 3'd3,
    CMD_SCALE       = 3'd4,
    CMD_STOP        = 3'd5
  } cmd_e;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_STARTED   = 3'd1,
    EV_TONE_END  = 3'd2,
    EV_ADVANCE   = 3'd3,
    EV_SCALE_END = 3'd4,
    EV_BUSY      = 3'd5,
    EV_EMPTY     = 3'd6
  } ev_e;

  // one input beat as held in the input register
  typedef struct packed {
    cmd_e              cmd;
    logic [FREQ_W-1:0] frequency;
    logic [PRE_W-1:0]  duty_pre;
    logic [DUR_W-1:0]  duration;
    logic [4:0]        note_slot;
    logic [POS_W-1:0]  note_count;
    logic              direction_up;
  } item_t;

  // one result beat
  typedef struct packed {
    ev_e               event_code;
    logic [FREQ_W-1:0] frequency;
    logic [DUTY_W-1:0] duty;
    logic              square;
    logic              busy;
    logic [POS_W-1:0]  position;
  } res_t;

  // note store write request
  typedef struct packed {
    logic              en;
    logic [POS_W-1:0]  addr;
    logic [FREQ_W-1:0] data;
  } note_wr_t;

  // next note lookup for a running scale
  typedef struct packed {
    logic             scale;
    logic [POS_W-1:0] addr;
  } prefetch_t;

endpackage

FILE: design/bts_duty.sv
module bts_duty (
  input  logic [13:0]                duty_hundredths_i,
  input  logic [4:0]                 res_bits_i,
  output logic [bts_pkg::PRE_W-1:0]  pre_o,
  input  logic [bts_pkg::PRE_W-1:0]  pre_i,
  output logic [bts_pkg::DUTY_W-1:0] duty_o
);

  logic [13:0] d_sat;
  logic [4:0]  bits;
  logic [33:0] scaled;
  logic [60:0] prod;

  // input side: full * d as a shift and subtract, pre-divided by 16
  always_comb begin
    d_sat  = (duty_hundredths_i > bts_pkg::DUTY_FULL) ? bts_pkg::DUTY_FULL : duty_hundredths_i;
    bits   = (res_bits_i > bts_pkg::MAX_RES_BITS) ? bts_pkg::MAX_RES_BITS : res_bits_i;
    scaled = ({20'd0, d_sat} << bits) - {20'd0, d_sat};
    pre_o  = scaled[33:4];
  end

  // stage side: divide by 625 through the reciprocal
  assign prod   = {31'd0, pre_i} * {30'd0, bts_pkg::DUTY_RECIP};
  assign duty_o = prod[bts_pkg::DUTY_SHIFT +: bts_pkg::DUTY_W];

endmodule

FILE: design/bts_notes.sv
module bts_notes #(
  parameter int MAX_NOTES = 32
) (
  input  logic                       clk_i,
  input  bts_pkg::note_wr_t          wr_i,
  input  logic                       rd_en_i,
  input  logic [bts_pkg::POS_W-1:0]  rd_addr_i,
  output logic [bts_pkg::FREQ_W-1:0] rd_data_o
);

  localparam int AW = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
  localparam logic [bts_pkg::POS_W:0] Depth = (bts_pkg::POS_W + 1)'(MAX_NOTES);

  logic [bts_pkg::FREQ_W-1:0] mem [MAX_NOTES];
  logic [bts_pkg::FREQ_W-1:0] rd_q;
  logic                       rd_ok;

  assign rd_ok = ({1'b0, rd_addr_i} < Depth);

  // write port, address already range checked
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr[AW-1:0]] <= wr_i.data;
    end
  end

  // registered read with write forwarding
  always_ff @(posedge clk_i) begin
    if (rd_en_i && rd_ok) begin
      if (wr_i.en && (wr_i.addr == rd_addr_i)) begin
        rd_q <= wr_i.data;
      end else begin
        rd_q <= mem[rd_addr_i[AW-1:0]];
      end
    end
  end

  assign rd_data_o = rd_q;

endmodule

FILE: design/bts_ctrl.sv
module bts_ctrl #(
  parameter int MAX_NOTES = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       fire_i,
  input  bts_pkg::item_t             item_i,
  input  logic [bts_pkg::DUTY_W-1:0] duty_i,
  input  logic [bts_pkg::FREQ_W-1:0] note_i,
  output bts_pkg::res_t              res_o,
  output bts_pkg::note_wr_t          wr_o,
  output bts_pkg::prefetch_t         pf_o
);

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_TONE  = 2'd1,
    MODE_SCALE = 2'd2
  } mode_e;

  localparam logic [bts_pkg::POS_W-1:0] NotesLim = bts_pkg::POS_W'(MAX_NOTES);

  mode_e                       mode_q, mode_d;
  logic [bts_pkg::DUR_W-1:0]   elapsed_q, elapsed_d;
  logic [bts_pkg::DUR_W-1:0]   hold_q, hold_d;
  logic [bts_pkg::POS_W-1:0]   pos_q, pos_d;
  logic [bts_pkg::POS_W-1:0]   len_q, len_d;
  logic                        asc_q, asc_d;
  logic [bts_pkg::FREQ_W-1:0]  freq_q, freq_d;
  logic [bts_pkg::DUTY_W-1:0]  duty_q, duty_d;
  logic                        sq_q, sq_d;
  bts_pkg::res_t               res_q, res_d;
  logic                        busy;
  logic [bts_pkg::DUR_W-1:0]   el_inc;
  logic                        asc_end;

  assign busy    = (mode_q == MODE_TONE) || (mode_q == MODE_SCALE);
  assign el_inc  = (elapsed_q == '1) ? elapsed_q : elapsed_q + 32'd1;
  assign asc_end = (({1'b0, pos_q} + 9'd1) >= {1'b0, len_q});

  // next state for the beat in the input register
  always_comb begin
    mode_d    = mode_q;
    elapsed_d = elapsed_q;
    hold_d    = hold_q;
    pos_d     = pos_q;
    len_d     = len_q;
    asc_d     = asc_q;
    freq_d    = freq_q;
    duty_d    = duty_q;
    sq_d      = sq_q;
    wr_o      = '{en: 1'b0, addr: {3'b000, item_i.note_slot}, data: item_i.frequency};
    res_d.event_code = bts_pkg::EV_NONE;
    if (fire_i) begin
      unique case (item_i.cmd)
        bts_pkg::CMD_TICK: begin
          if (busy) begin
            elapsed_d = el_inc;
            if (el_inc >= hold_q) begin
              if (mode_q == MODE_TONE) begin
                mode_d = MODE_IDLE;
                freq_d = '0;
                duty_d = '0;
                sq_d   = 1'b0;
                res_d.event_code = bts_pkg::EV_TONE_END;
              end else if (asc_q ? asc_end : (pos_q == '0)) begin
                mode_d = MODE_IDLE;
                freq_d = '0;
                duty_d = '0;
                sq_d   = 1'b0;
                res_d.event_code = bts_pkg::EV_SCALE_END;
              end else begin
                pos_d     = asc_q ? pos_q + 8'd1 : pos_q - 8'd1;
                freq_d    = note_i;
                elapsed_d = '0;
                res_d.event_code = bts_pkg::EV_ADVANCE;
              end
            end
          end
        end
        bts_pkg::CMD_DUTY_TONE, bts_pkg::CMD_SQUARE_TONE: begin
          if (busy) begin
            res_d.event_code = bts_pkg::EV_BUSY;
          end else begin
            mode_d    = MODE_TONE;
            freq_d    = item_i.frequency;
            duty_d    = (item_i.cmd == bts_pkg::CMD_DUTY_TONE) ? duty_i : '0;
            sq_d      = (item_i.cmd == bts_pkg::CMD_SQUARE_TONE);
            elapsed_d = '0;
            hold_d    = item_i.duration;
            res_d.event_code = bts_pkg::EV_STARTED;
          end
        end
        bts_pkg::CMD_LOAD_NOTE: begin
          wr_o.en = ({3'b000, item_i.note_slot} < NotesLim);
        end
        bts_pkg::CMD_SCALE: begin
          if (busy) begin
            res_d.event_code = bts_pkg::EV_BUSY;
          end else if (item_i.note_count == '0) begin
            res_d.event_code = bts_pkg::EV_EMPTY;
          end else begin
            mode_d    = MODE_SCALE;
            len_d     = item_i.note_count;
            asc_d     = item_i.direction_up;
            pos_d     = item_i.direction_up ? '0 : item_i.note_count - 8'd1;
            freq_d    = note_i;
            duty_d    = '0;
            sq_d      = 1'b1;
            elapsed_d = '0;
            hold_d    = item_i.duration;
            res_d.event_code = bts_pkg::EV_STARTED;
          end
        end
        bts_pkg::CMD_STOP: begin
          mode_d = MODE_IDLE;
          freq_d = '0;
          duty_d = '0;
          sq_d   = 1'b0;
        end
        default: begin
        end
      endcase
    end
    res_d.frequency = freq_d;
    res_d.duty      = duty_d;
    res_d.square    = sq_d;
    res_d.busy      = (mode_d == MODE_TONE) || (mode_d == MODE_SCALE);
    res_d.position  = (mode_d == MODE_SCALE) ? pos_d : '0;
  end

  // note to fetch for the next advance
  assign pf_o.scale = (mode_d == MODE_SCALE);
  assign pf_o.addr  = asc_d ? pos_d + 8'd1 : pos_d - 8'd1;

  // state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_IDLE;
      elapsed_q <= '0;
      hold_q    <= '0;
      pos_q     <= '0;
      len_q     <= '0;
      asc_q     <= 1'b1;
      freq_q    <= '0;
      duty_q    <= '0;
      sq_q      <= 1'b0;
      res_q     <= '0;
    end else begin
      mode_q    <= mode_d;
      elapsed_q <= elapsed_d;
      hold_q    <= hold_d;
      pos_q     <= pos_d;
      len_q     <= len_d;
      asc_q     <= asc_d;
      freq_q    <= freq_d;
      duty_q    <= duty_d;
      sq_q      <= sq_d;
      if (fire_i) begin
        res_q <= res_d;
      end
    end
  end

  assign res_o = res_q;

endmodule

FILE: design/buzzer_tone_scale_sequencer_unit.sv
// Tone controller for one PWM channel.
// Input channel (in_valid_i / in_ready_o): one command beat carrying command, frequency,
// duty, duration, note slot, note count and direction. Commands are tick of one ms,
// duty tone, square tone, load note, scale and stop.
// Output channel (out_valid_o / out_ready_i): exactly one result beat per command with
// the event code, driven frequency, duty count, square flag, busy flag and note position.
// Configuration channel (cfg_valid_i / cfg_ready_o): PWM resolution in bits, always
// ready; write it only while no command is in flight.
// A beat is taken into the input register and its result is held in the result register.
// Throughput: one beat per cycle while the output is not stalled, set by the single
// input register and the result register; the note store read is issued on acceptance.
// Reset: channel silent, not busy, resolution 8. The note store is not cleared and
// holds nothing defined until loaded.
// Stall: the result register holds its beat while out_ready_i is low, the input
// register takes one more beat, and then in_ready_o drops.
`include "buzzer_tone_scale_sequencer_unit_macros.svh"

module buzzer_tone_scale_sequencer_unit #(
  parameter int MAX_NOTES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [4:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  command_i,
  input  logic [15:0] frequency_i,
  input  logic [13:0] duty_hundredths_i,
  input  logic [31:0] duration_ms_i,
  input  logic [4:0]  note_slot_i,
  input  logic [7:0]  note_count_i,
  input  logic        direction_up_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  event_res_o,
  output logic [15:0] tone_frequency_o,
  output logic [19:0] duty_value_o,
  output logic        square_mode_o,
  output logic        busy_res_o,
  output logic [7:0]  note_position_o
);

  localparam logic [bts_pkg::POS_W-1:0] NotesLim = bts_pkg::POS_W'(MAX_NOTES);

  logic [4:0]                 res_bits_q;
  bts_pkg::item_t             s1_q;
  logic                       s1_valid_q;
  logic                       out_valid_q;
  logic                       s1_fire;
  logic                       in_acc;
  logic [bts_pkg::POS_W-1:0]  count_sat;
  logic [bts_pkg::POS_W-1:0]  start_addr;
  logic [bts_pkg::POS_W-1:0]  rd_addr;
  logic [bts_pkg::PRE_W-1:0]  duty_pre;
  logic [bts_pkg::DUTY_W-1:0] duty_val;
  logic [bts_pkg::FREQ_W-1:0] note_data;
  bts_pkg::res_t              res;
  bts_pkg::note_wr_t          note_wr;
  bts_pkg::prefetch_t         pf;

  // handshake
  assign s1_fire     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !s1_valid_q || s1_fire;
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  // resolution register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_bits_q <= 5'd8;
    end else if (cfg_valid_i) begin
      res_bits_q <= cfg_data_i;
    end
  end

  // saturated scale length and first note of a scale
  assign count_sat  = (note_count_i > NotesLim) ? NotesLim : note_count_i;
  assign start_addr = direction_up_i ? '0 : count_sat - 8'd1;
  assign rd_addr    = pf.scale ? pf.addr : start_addr;

  // input register
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q.cmd          <= bts_pkg::cmd_e'(command_i);
      s1_q.frequency    <= frequency_i;
      s1_q.duty_pre     <= duty_pre;
      s1_q.duration     <= duration_ms_i;
      s1_q.note_slot    <= note_slot_i;
      s1_q.note_count   <= count_sat;
      s1_q.direction_up <= direction_up_i;
    end
  end

  // beat valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  bts_duty u_duty (
    .duty_hundredths_i (duty_hundredths_i),
    .res_bits_i        (res_bits_q),
    .pre_o             (duty_pre),
    .pre_i             (s1_q.duty_pre),
    .duty_o            (duty_val)
  );

  bts_notes #(
    .MAX_NOTES (MAX_NOTES)
  ) u_notes (
    .clk_i     (clk_i),
    .wr_i      (note_wr),
    .rd_en_i   (in_acc),
    .rd_addr_i (rd_addr),
    .rd_data_o (note_data)
  );

  bts_ctrl #(
    .MAX_NOTES (MAX_NOTES)
  ) u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (s1_fire),
    .item_i (s1_q),
    .duty_i (duty_val),
    .note_i (note_data),
    .res_o  (res),
    .wr_o   (note_wr),
    .pf_o   (pf)
  );

  // result ports
  assign out_valid_o      = out_valid_q;
  assign event_res_o      = res.event_code;
  assign tone_frequency_o = res.frequency;
  assign duty_value_o     = res.duty;
  assign square_mode_o    = res.square;
  assign busy_res_o       = res.busy;
  assign note_position_o  = res.position;

  // checks
  `BTS_ASSERT(a_fire_fills_out, s1_fire |=> out_valid_q, "processed beat did not reach output")
  `BTS_ASSERT(a_square_busy, out_valid_q && res.square |-> res.busy, "square tone while idle")
  `BTS_ASSERT(a_duty_excl, out_valid_q && (res.duty != '0) |-> !res.square && res.busy, "duty count in wrong mode")
  `BTS_ASSERT(a_pos_scale, out_valid_q && (res.position != '0) |-> res.square && res.busy, "note position outside a scale")
  `BTS_ASSERT(a_stall_holds, out_valid_q && !out_ready_i && s1_valid_q |-> !in_ready_o, "beat taken while both stages full")
  `BTS_ASSERT_RST(a_rst_empty, !rst_ni |=> !out_valid_q, "result valid during reset")

endmodule

FILE: tb/sv/tb_buzzer_tone_scale_sequencer_unit.sv
`timescale 1ns / 100ps

module tb_buzzer_tone_scale_sequencer_unit;

  localparam int          NOTE_SLOTS  = 32;
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          SETTLE_CYC  = 8;
  localparam logic [2:0]  CMD_SPARE_6 = 3'd6;
  localparam logic [2:0]  CMD_SPARE_7 = 3'd7;

  typedef enum logic [1:0] {
    PLAY_IDLE  = 2'd0,
    PLAY_TONE  = 2'd1,
    PLAY_SCALE = 2'd2
  } play_e;

  // one command beat as driven on the input channel
  typedef struct {
    logic [2:0]  cmd;
    logic [15:0] freq;
    logic [13:0] duty;
    logic [31:0] dur;
    logic [4:0]  slot;
    logic [7:0]  count;
    logic        up;
  } cmd_beat_t;

  logic        clk_i;
  logic        rst_ni            = 1'b0;
  logic        cfg_valid_i       = 1'b0;
  logic        cfg_ready_o;
  logic [4:0]  cfg_data_i        = '0;
  logic        in_valid_i        = 1'b0;
  logic        in_ready_o;
  logic [2:0]  command_i         = '0;
  logic [15:0] frequency_i       = '0;
  logic [13:0] duty_hundredths_i = '0;
  logic [31:0] duration_ms_i     = '0;
  logic [4:0]  note_slot_i       = '0;
  logic [7:0]  note_count_i      = '0;
  logic        direction_up_i    = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i       = 1'b0;
  logic [2:0]  event_res_o;
  logic [15:0] tone_frequency_o;
  logic [19:0] duty_value_o;
  logic        square_mode_o;
  logic        busy_res_o;
  logic [7:0]  note_position_o;

  // channel state mirror
  logic [4:0]  res_bits   = 5'd8;
  play_e       play       = PLAY_IDLE;
  logic [31:0] elapsed    = '0;
  logic [31:0] hold       = '0;
  logic [8:0]  scale_pos  = '0;
  logic [7:0]  scale_len  = '0;
  logic        scale_up   = 1'b1;
  logic [15:0] cur_freq   = '0;
  logic [19:0] cur_duty   = '0;
  logic        cur_square = 1'b0;
  logic [15:0] notes [NOTE_SLOTS];
  bit          note_loaded [NOTE_SLOTS];

  bts_pkg::res_t awaited_reports [$];
  int unsigned idle_pct       = 0;
  int unsigned stall_pct      = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;

  buzzer_tone_scale_sequencer_unit u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .command_i         (command_i),
    .frequency_i       (frequency_i),
    .duty_hundredths_i (duty_hundredths_i),
    .duration_ms_i     (duration_ms_i),
    .note_slot_i       (note_slot_i),
    .note_count_i      (note_count_i),
    .direction_up_i    (direction_up_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .event_res_o       (event_res_o),
    .tone_frequency_o  (tone_frequency_o),
    .duty_value_o      (duty_value_o),
    .square_mode_o     (square_mode_o),
    .busy_res_o        (busy_res_o),
    .note_position_o   (note_position_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // channel predictor
  // ---------------------------------------------------------------------------

  function automatic void mute_channel();
    play       = PLAY_IDLE;
    cur_freq   = '0;
    cur_duty   = '0;
    cur_square = 1'b0;
  endfunction

  // floor(full_scale * min(hundredths, 10000) / 10000)
  function automatic logic [19:0] duty_for(input logic [13:0] hundredths);
    logic [63:0] full;
    logic [63:0] d;
    full = (64'd1 << ((res_bits > bts_pkg::MAX_RES_BITS) ? bts_pkg::MAX_RES_BITS
                                                         : res_bits)) - 64'd1;
    d    = (hundredths > bts_pkg::DUTY_FULL) ? 64'(bts_pkg::DUTY_FULL) : 64'(hundredths);
    return 20'((full * d) / 64'(bts_pkg::DUTY_FULL));
  endfunction

  function automatic bts_pkg::res_t advance_channel(input cmd_beat_t b);
    bts_pkg::res_t r;
    bts_pkg::ev_e  ev;
    logic [7:0]    cnt;
    bit            busy;
    ev   = bts_pkg::EV_NONE;
    busy = (play != PLAY_IDLE);
    case (b.cmd)
      bts_pkg::CMD_TICK: begin
        if (busy) begin
          if (elapsed != 32'hFFFF_FFFF) elapsed = elapsed + 32'd1;
          if (elapsed >= hold) begin
            if (play == PLAY_TONE) begin
              mute_channel();
              ev = bts_pkg::EV_TONE_END;
            end else if (scale_up ? (scale_pos + 9'd1 >= {1'b0, scale_len})
                                  : (scale_pos == '0)) begin
              mute_channel();
              ev = bts_pkg::EV_SCALE_END;
            end else begin
              scale_pos = scale_up ? scale_pos + 9'd1 : scale_pos - 9'd1;
              cur_freq  = notes[scale_pos];
              elapsed   = '0;
              ev        = bts_pkg::EV_ADVANCE;
            end
          end
        end
      end
      bts_pkg::CMD_DUTY_TONE, bts_pkg::CMD_SQUARE_TONE: begin
        if (busy) begin
          ev = bts_pkg::EV_BUSY;
        end else begin
          play       = PLAY_TONE;
          cur_freq   = b.freq;
          cur_duty   = (b.cmd == bts_pkg::CMD_DUTY_TONE) ? duty_for(b.duty) : '0;
          cur_square = (b.cmd == bts_pkg::CMD_SQUARE_TONE);
          elapsed    = '0;
          hold       = b.dur;
          ev         = bts_pkg::EV_STARTED;
        end
      end
      bts_pkg::CMD_LOAD_NOTE: begin
        notes[b.slot]       = b.freq;
        note_loaded[b.slot] = 1'b1;
      end
      bts_pkg::CMD_SCALE: begin
        if (busy) begin
          ev = bts_pkg::EV_BUSY;
        end else if (b.count == '0) begin
          ev = bts_pkg::EV_EMPTY;
        end else begin
          cnt        = (b.count > 8'(NOTE_SLOTS)) ? 8'(NOTE_SLOTS) : b.count;
          play       = PLAY_SCALE;
          scale_len  = cnt;
          scale_up   = b.up;
          scale_pos  = b.up ? 9'd0 : 9'(cnt - 8'd1);
          cur_freq   = notes[scale_pos];
          cur_duty   = '0;
          cur_square = 1'b1;
          elapsed    = '0;
          hold       = b.dur;
          ev         = bts_pkg::EV_STARTED;
        end
      end
      bts_pkg::CMD_STOP: mute_channel();
      default: ;
    endcase
    r.event_code = ev;
    r.frequency  = cur_freq;
    r.duty       = cur_duty;
    r.square     = cur_square;
    r.busy       = (play != PLAY_IDLE);
    r.position   = (play == PLAY_SCALE) ? scale_pos[7:0] : '0;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // result checker and receiver stalls
  // ---------------------------------------------------------------------------

  task automatic flag_mismatch(input string what, input int unsigned want,
                               input int unsigned got);
    if (mismatch_count < 10)
      $display("mismatch %s: expected %0d, actual %0d", what, want, got);
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin
    bts_pkg::res_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (awaited_reports.size() == 0) begin
          flag_mismatch("unexpected result beat, event", 0, 32'(event_res_o));
        end else begin
          want = awaited_reports.pop_front();
          if (event_res_o != want.event_code)
            flag_mismatch("event", 32'(want.event_code), 32'(event_res_o));
          if (tone_frequency_o != want.frequency)
            flag_mismatch("frequency", 32'(want.frequency), 32'(tone_frequency_o));
          if (duty_value_o != want.duty)
            flag_mismatch("duty", 32'(want.duty), 32'(duty_value_o));
          if (square_mode_o != want.square)
            flag_mismatch("square", 32'(want.square), 32'(square_mode_o));
          if (busy_res_o != want.busy)
            flag_mismatch("busy", 32'(want.busy), 32'(busy_res_o));
          if (note_position_o != want.position)
            flag_mismatch("position", 32'(want.position), 32'(note_position_o));
        end
      end
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // drive one command beat and record its expected report on acceptance
  task automatic send_beat(input cmd_beat_t b);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    command_i         <= b.cmd;
    frequency_i       <= b.freq;
    duty_hundredths_i <= b.duty;
    duration_ms_i     <= b.dur;
    note_slot_i       <= b.slot;
    note_count_i      <= b.count;
    direction_up_i    <= b.up;
    do @(posedge clk_i); while (!in_ready_o);
    awaited_reports.push_back(advance_channel(b));
  endtask

  // stop sending, wait for all reports, then let the design settle
  task automatic drain();
    in_valid_i <= 1'b0;
    while (awaited_reports.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_resolution(input logic [4:0] bits);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= bits;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    res_bits = bits;
  endtask

  // mostly short durations so ticks end tones, some full range ones
  function automatic logic [31:0] pick_duration();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(0, 4);
    if (r < 90) return $urandom_range(5, 40);
    return $urandom;
  endfunction

  function automatic cmd_beat_t make_beat(input logic [2:0] cmd);
    cmd_beat_t b;
    b.cmd   = cmd;
    b.freq  = 16'($urandom_range(0, 65535));
    b.duty  = ($urandom_range(99) < 85) ? 14'($urandom_range(0, 10000))
                                        : 14'($urandom_range(10001, 16383));
    b.dur   = pick_duration();
    b.slot  = 5'($urandom_range(0, NOTE_SLOTS - 1));
    b.count = 8'($urandom_range(0, 255));
    b.up    = 1'($urandom_range(1));
    return b;
  endfunction

  // number of loaded notes counted up from slot 0
  function automatic int unsigned loaded_prefix();
    for (int i = 0; i < NOTE_SLOTS; i++)
      if (!note_loaded[i]) return i;
    return NOTE_SLOTS;
  endfunction

  // scale length that only ever reads loaded notes
  function automatic logic [7:0] safe_count();
    int unsigned p;
    p = loaded_prefix();
    if (p == 0 || $urandom_range(19) == 0) return '0;
    if (p == NOTE_SLOTS && $urandom_range(3) == 0)
      return 8'($urandom_range(NOTE_SLOTS + 1, 255));
    return 8'($urandom_range(1, p));
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  task automatic test_idle_commands();
    send_beat(make_beat(bts_pkg::CMD_TICK));
    send_beat(make_beat(bts_pkg::CMD_STOP));
    send_beat(make_beat(CMD_SPARE_6));
    send_beat(make_beat(CMD_SPARE_7));
  endtask

  task automatic test_note_loads();
    cmd_beat_t b;
    b = make_beat(bts_pkg::CMD_LOAD_NOTE); b.slot = 5'd0; b.freq = 16'hFFFF; send_beat(b);
    b = make_beat(bts_pkg::CMD_LOAD_NOTE); b.slot = 5'd1; b.freq = 16'h0000; send_beat(b);
    b = make_beat(bts_pkg::CMD_LOAD_NOTE); b.slot = 5'd2; b.freq = 16'd440;  send_beat(b);
  endtask

  task automatic test_timed_tones();
    cmd_beat_t b;
    // duty above full scale, zero duration ends on first tick
    b = make_beat(bts_pkg::CMD_DUTY_TONE); b.freq = 16'hFFFF; b.duty = 14'h3FFF;
    b.dur = '0;
    send_beat(b);
    send_beat(make_beat(bts_pkg::CMD_TICK));
    // square tone, busy starts rejected while it plays
    b = make_beat(bts_pkg::CMD_SQUARE_TONE); b.freq = '0; b.dur = 32'd2; send_beat(b);
    b = make_beat(bts_pkg::CMD_DUTY_TONE); b.duty = '0; send_beat(b);
    b = make_beat(bts_pkg::CMD_SCALE); b.count = 8'd1; send_beat(b);
    send_beat(make_beat(bts_pkg::CMD_TICK));
    send_beat(make_beat(bts_pkg::CMD_TICK));
  endtask

  task automatic test_scales();
    cmd_beat_t b;
    b = make_beat(bts_pkg::CMD_SCALE); b.count = '0; send_beat(b);
    // ascending, with a note reloaded while the scale plays
    b = make_beat(bts_pkg::CMD_SCALE); b.count = 8'd3; b.up = 1'b1; b.dur = '0; send_beat(b);
    b = make_beat(bts_pkg::CMD_LOAD_NOTE); b.slot = 5'd2; b.freq = 16'd880; send_beat(b);
    send_beat(make_beat(bts_pkg::CMD_TICK));
    send_beat(make_beat(bts_pkg::CMD_TICK));
    send_beat(make_beat(bts_pkg::CMD_TICK));
    // descending ends after slot 0 has played
    b = make_beat(bts_pkg::CMD_SCALE); b.count = 8'd2; b.up = 1'b0; b.dur = '0; send_beat(b);
    send_beat(make_beat(bts_pkg::CMD_TICK));
    send_beat(make_beat(bts_pkg::CMD_TICK));
    // stop in the middle of a long scale
    b = make_beat(bts_pkg::CMD_SCALE); b.count = 8'd3; b.up = 1'b0; b.dur = 32'hFFFF_FFFF;
    send_beat(b);
    send_beat(make_beat(bts_pkg::CMD_STOP));
  endtask

  // full scale at zero, one and clamped resolution
  task automatic test_resolution();
    cmd_beat_t b;
    logic [4:0] widths [3];
    widths = '{5'd0, 5'd1, 5'd31};
    foreach (widths[i]) begin
      write_resolution(widths[i]);
      b = make_beat(bts_pkg::CMD_DUTY_TONE); b.duty = bts_pkg::DUTY_FULL; send_beat(b);
      send_beat(make_beat(bts_pkg::CMD_STOP));
    end
  endtask

  task automatic test_random_traffic(input int unsigned beats, input int unsigned in_pct,
                                     input int unsigned out_pct, input logic [4:0] bits);
    cmd_beat_t   b;
    int unsigned r;
    write_resolution(bits);
    idle_pct  = in_pct;
    stall_pct = out_pct;
    repeat (beats) begin
      r = $urandom_range(99);
      if (r < 40)      b = make_beat(bts_pkg::CMD_TICK);
      else if (r < 50) b = make_beat(bts_pkg::CMD_DUTY_TONE);
      else if (r < 58) b = make_beat(bts_pkg::CMD_SQUARE_TONE);
      else if (r < 72) b = make_beat(bts_pkg::CMD_LOAD_NOTE);
      else if (r < 86) b = make_beat(bts_pkg::CMD_SCALE);
      else if (r < 95) b = make_beat(bts_pkg::CMD_STOP);
      else             b = make_beat($urandom_range(1) ? CMD_SPARE_6 : CMD_SPARE_7);
      if (b.cmd == bts_pkg::CMD_LOAD_NOTE && loaded_prefix() < NOTE_SLOTS &&
          $urandom_range(1))
        b.slot = 5'(loaded_prefix());
      if (b.cmd == bts_pkg::CMD_SCALE)
        b.count = safe_count();
      send_beat(b);
    end
  endtask

  initial begin
    foreach (notes[i]) begin
      notes[i]       = '0;
      note_loaded[i] = 1'b0;
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_idle_commands();
    test_note_loads();
    test_timed_tones();
    test_scales();
    test_resolution();
    test_random_traffic(360, 0, 0, 5'd20);
    test_random_traffic(360, 72, 0, 5'd1);
    test_random_traffic(360, 0, 72, 5'd8);
    test_random_traffic(360, 14, 14, 5'($urandom_range(2, 19)));
    drain();

    if (mismatch_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
